// File: rtl/shr_pkg.sv
// Package for the stereo Hermite resampler: widths, fixed-point constants,
// sequencer codes and the control struct between the sequencer and the datapath.
// Used by the stream interfaces, shr_datapath and stereo_hermite_resampler.
package shr_pkg;

  // Sample and register widths.
  localparam int SAMPLE_W     = 16;
  localparam int RATIO_W      = 21;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_STEP_RATIO = 1'b0;

  // Phase format and run length.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_UPSAMPLE    = 16;
  localparam int RUN_CAP         = MAX_UPSAMPLE + 1;
  localparam int RUN_W           = $clog2(RUN_CAP + 1);
  localparam int UP_SHIFT        = (PHASE_FRAC_BITS >= 16) ? PHASE_FRAC_BITS - 16 : 0;
  localparam int DOWN_SHIFT      = (PHASE_FRAC_BITS >= 16) ? 0 : 16 - PHASE_FRAC_BITS;
  localparam int STEP_PH_W       = RATIO_W + UP_SHIFT;
  localparam int P_W             = PHASE_FRAC_BITS + 1;
  localparam int PH_W            = ((P_W > STEP_PH_W) ? P_W : STEP_PH_W) + 1;
  localparam logic [PH_W-1:0] PH_ONE = {{(PH_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;

  // Shared multiplier and accumulator widths.
  localparam int MA_W  = PHASE_FRAC_BITS + 3;
  localparam int MB_W  = (PHASE_FRAC_BITS + 2 > 18) ? PHASE_FRAC_BITS + 2 : 18;
  localparam int PR_W  = MA_W + MB_W;
  localparam int ACC_W = PR_W + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [3:0] hist_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH
  } shr_state_e;

  // One step of the per-output calculation schedule.
  localparam int CS_W = 4;
  typedef enum logic [CS_W-1:0] {
    CS_PP,
    CS_MU3,
    CS_COEF,
    CS_L0,
    CS_L1,
    CS_L2,
    CS_L3,
    CS_R0,
    CS_R1,
    CS_R2,
    CS_R3,
    CS_DRAIN,
    CS_FIN
  } calc_step_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MOP_PP,
    MOP_MU3,
    MOP_A0,
    MOP_A1,
    MOP_A2,
    MOP_A3
  } mul_op_e;

  typedef struct packed {
    mul_op_e mop;
    logic    right;
    logic    mu2_en;
    logic    coef_en;
    logic    acc_en;
    logic    acc_load;
    logic    fin_l;
    logic    fin_r;
  } shr_ctrl_t;

endpackage

// File: rtl/shr_if.sv
// Valid/ready stream interfaces for the resampler's input and output items.
// Depends on shr_pkg for the sample width.
interface shr_in_if import shr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface shr_out_if import shr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  logic    last_of_run;

  modport source (output valid, output left_out, output right_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input last_of_run,
                  output ready);
endinterface

// File: rtl/shr_datapath.sv
// Interpolation datapath: one shared signed multiplier, the Catmull-Rom
// coefficient registers, an accumulator and the scale/round/clamp stage.
// Depends on shr_pkg; driven step by step by the sequencer in the top level.
module shr_datapath import shr_pkg::*; (
  input  logic             clk_i,
  input  shr_ctrl_t        ctrl_i,
  input  logic [P_W-1:0]   phase_i,
  input  hist_t            left_hist_i,
  input  hist_t            right_hist_i,
  output sample_t          left_res_o,
  output sample_t          right_res_o
);

  localparam logic signed [MA_W-1:0]  ONE_A   = MA_W'(1) << PHASE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(32768));

  logic signed [PR_W-1:0]  prod_q;
  logic signed [PR_W-1:0]  prod_d;
  logic [P_W-1:0]          mu2_q;
  logic signed [MA_W-1:0]  coef_q [4];
  logic signed [MA_W-1:0]  coef_d [4];
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] prod_ext;
  sample_t                 res_l_q;
  sample_t                 res_r_q;

  logic signed [MA_W-1:0]  op_a;
  logic signed [MB_W-1:0]  op_b;
  logic [P_W-1:0]          prod_hi;
  logic signed [MA_W-1:0]  p_a;
  logic signed [MA_W-1:0]  mu2_a;
  logic signed [MA_W-1:0]  mu3_a;
  hist_t                   h;
  logic [SAMPLE_W:0]       two_h1;
  logic [SAMPLE_W:0]       two_h2;
  logic [SAMPLE_W:0]       d20;
  logic [SAMPLE_W:0]       d31;
  logic signed [ACC_W-1:0] quo;
  logic signed [ACC_W-1:0] quo_rnd;
  sample_t                 fin_val;

  // Last product scaled back to phase format: mu2 after p*p, mu3 after mu2*p.
  assign prod_hi = prod_q[PHASE_FRAC_BITS +: P_W];
  assign p_a     = {{(MA_W-P_W){1'b0}}, phase_i};
  assign mu2_a   = {{(MA_W-P_W){1'b0}}, mu2_q};
  assign mu3_a   = {{(MA_W-P_W){1'b0}}, prod_hi};

  // Coefficients of the four history taps.
  always_comb begin
    coef_d[0] = (mu3_a <<< 1) - (mu2_a + (mu2_a <<< 1)) + ONE_A;
    coef_d[1] = mu3_a - (mu2_a <<< 1) + p_a;
    coef_d[2] = mu3_a - mu2_a;
    coef_d[3] = (mu2_a + (mu2_a <<< 1)) - (mu3_a <<< 1);
  end

  // Tap terms of the selected channel, 17 bits signed.
  assign h      = ctrl_i.right ? right_hist_i : left_hist_i;
  assign two_h1 = {h[1], 1'b0};
  assign two_h2 = {h[2], 1'b0};
  assign d20    = {h[2][SAMPLE_W-1], h[2]} - {h[0][SAMPLE_W-1], h[0]};
  assign d31    = {h[3][SAMPLE_W-1], h[3]} - {h[1][SAMPLE_W-1], h[1]};

  // Operand selection of the shared multiplier.
  always_comb begin
    op_a = p_a;
    op_b = {{(MB_W-P_W){1'b0}}, phase_i};
    unique case (ctrl_i.mop)
      MOP_PP: begin
        op_a = p_a;
      end
      MOP_MU3: begin
        op_a = {{(MA_W-P_W){1'b0}}, prod_hi};
      end
      MOP_A0: begin
        op_a = coef_q[0];
        op_b = {{(MB_W-SAMPLE_W-1){two_h1[SAMPLE_W]}}, two_h1};
      end
      MOP_A1: begin
        op_a = coef_q[1];
        op_b = {{(MB_W-SAMPLE_W-1){d20[SAMPLE_W]}}, d20};
      end
      MOP_A2: begin
        op_a = coef_q[2];
        op_b = {{(MB_W-SAMPLE_W-1){d31[SAMPLE_W]}}, d31};
      end
      MOP_A3: begin
        op_a = coef_q[3];
        op_b = {{(MB_W-SAMPLE_W-1){two_h2[SAMPLE_W]}}, two_h2};
      end
      default: begin
        op_a = p_a;
      end
    endcase
  end

  assign prod_d   = op_a * op_b;
  assign prod_ext = ACC_W'(prod_q);
  assign acc_d    = ctrl_i.acc_load ? prod_ext : acc_q + prod_ext;

  // Divide by 2.0 in phase units, truncating toward zero, then clamp.
  always_comb begin
    quo     = acc_q >>> (PHASE_FRAC_BITS + 1);
    quo_rnd = quo + ACC_W'(acc_q[ACC_W-1] && (|acc_q[PHASE_FRAC_BITS:0]));
    if (quo_rnd > SAT_MAX) begin
      fin_val = SAMPLE_W'(SAT_MAX);
    end else if (quo_rnd < SAT_MIN) begin
      fin_val = SAMPLE_W'(SAT_MIN);
    end else begin
      fin_val = quo_rnd[SAMPLE_W-1:0];
    end
  end

  // Datapath registers; all payload, no reset needed.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.mu2_en) begin
      mu2_q <= prod_hi;
    end
    if (ctrl_i.coef_en) begin
      coef_q <= coef_d;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.fin_l) begin
      res_l_q <= fin_val;
    end
    if (ctrl_i.fin_r) begin
      res_r_q <= fin_val;
    end
  end

  assign left_res_o  = res_l_q;
  assign right_res_o = res_r_q;

endmodule

// File: rtl/stereo_hermite_resampler.sv
// Stereo Catmull-Rom resampler. An input item causes either no output or k
// output items (k <= 17), and no new input is taken while they are computed:
// each output pair needs ten products on the one shared multiplier plus the
// coefficient, rounding and hand-off steps. Reset (rst_ni low) sets the step
// ratio to 1.0 and clears both histories, the phase and the output valid flag
// at once.
module stereo_hermite_resampler import shr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  shr_in_if.sink               in_i,
  shr_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  shr_state_e         state_q, state_d;
  calc_step_e         cstep_q, cstep_d;
  logic [RATIO_W-1:0] ratio_q;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [RUN_W-1:0]   run_q, run_d;
  hist_t              left_hist_q;
  hist_t              right_hist_q;
  logic               out_vld_q, out_vld_d;
  sample_t            out_left_q;
  sample_t            out_right_q;
  logic               out_last_q;
  logic               out_load;
  logic               out_last_d;

  logic               cfg_wr;
  logic               in_acc;
  logic [PH_W-1:0]    step_ph;
  logic [PH_W-1:0]    phase_nx;
  logic               run_more;
  shr_ctrl_t          ctrl;
  sample_t            res_l;
  sample_t            res_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP_RATIO);
  assign prdata = (paddr[2] == REG_STEP_RATIO) ? PDATA_W'(ratio_q) : '0;

  // Step ratio in phase units and the phase after the current output.
  assign step_ph  = (PH_W'(ratio_q) << UP_SHIFT) >> DOWN_SHIFT;
  assign phase_nx = phase_q + step_ph;
  assign run_more = (phase_nx <= PH_ONE) && (run_q < RUN_W'(RUN_CAP - 1));

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Sequencer: next state, phase bookkeeping and datapath controls.
  always_comb begin
    state_d    = state_q;
    cstep_d    = cstep_q;
    phase_d    = phase_q;
    run_d      = run_q;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    out_vld_d  = out_vld_q && !out_o.ready;
    ctrl       = '{mop: MOP_PP, right: 1'b0, mu2_en: 1'b0, coef_en: 1'b0,
                   acc_en: 1'b0, acc_load: 1'b0, fin_l: 1'b0, fin_r: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (phase_q <= PH_ONE) begin
            state_d = ST_CALC;
            cstep_d = CS_PP;
            run_d   = '0;
          end else begin
            phase_d = phase_q - PH_ONE;
          end
        end
      end
      ST_CALC: begin
        cstep_d = calc_step_e'(cstep_q + CS_W'(1));
        if (cstep_q == CS_FIN) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_vld_q || out_o.ready) begin
          out_load   = 1'b1;
          out_vld_d  = 1'b1;
          out_last_d = !run_more;
          if (run_more) begin
            phase_d = phase_nx;
            run_d   = run_q + RUN_W'(1);
            state_d = ST_CALC;
            cstep_d = CS_PP;
          end else begin
            phase_d = (phase_nx > PH_ONE) ? phase_nx - PH_ONE : '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Multiply schedule of one output pair; products land in prod_q in the next cycle.
    if (state_q == ST_CALC) begin
      unique case (cstep_q)
        CS_PP: begin
          ctrl.mop = MOP_PP;
        end
        CS_MU3: begin
          ctrl.mop    = MOP_MU3;
          ctrl.mu2_en = 1'b1;
        end
        CS_COEF: begin
          ctrl.coef_en = 1'b1;
        end
        CS_L0: begin
          ctrl.mop = MOP_A0;
        end
        CS_L1: begin
          ctrl.mop      = MOP_A1;
          ctrl.acc_en   = 1'b1;
          ctrl.acc_load = 1'b1;
        end
        CS_L2: begin
          ctrl.mop    = MOP_A2;
          ctrl.acc_en = 1'b1;
        end
        CS_L3: begin
          ctrl.mop    = MOP_A3;
          ctrl.acc_en = 1'b1;
        end
        CS_R0: begin
          ctrl.mop    = MOP_A0;
          ctrl.right  = 1'b1;
          ctrl.acc_en = 1'b1;
        end
        CS_R1: begin
          ctrl.mop      = MOP_A1;
          ctrl.right    = 1'b1;
          ctrl.acc_en   = 1'b1;
          ctrl.acc_load = 1'b1;
          ctrl.fin_l    = 1'b1;
        end
        CS_R2: begin
          ctrl.mop    = MOP_A2;
          ctrl.right  = 1'b1;
          ctrl.acc_en = 1'b1;
        end
        CS_R3: begin
          ctrl.mop    = MOP_A3;
          ctrl.right  = 1'b1;
          ctrl.acc_en = 1'b1;
        end
        CS_DRAIN: begin
          ctrl.acc_en = 1'b1;
        end
        CS_FIN: begin
          ctrl.fin_r = 1'b1;
        end
        default: begin
          ctrl.mop = MOP_PP;
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cstep_q <= CS_PP;
    end else begin
      state_q <= state_d;
      cstep_q <= cstep_d;
    end
  end

  // Step ratio, phase, run count, histories and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q      <= RATIO_RESET;
      phase_q      <= '0;
      run_q        <= '0;
      left_hist_q  <= '0;
      right_hist_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      run_q     <= run_d;
      if (cfg_wr) begin
        ratio_q      <= pwdata[RATIO_W-1:0];
        phase_q      <= '0;
        left_hist_q  <= '0;
        right_hist_q <= '0;
      end else begin
        phase_q <= phase_d;
        if (in_acc) begin
          left_hist_q  <= {in_i.left_sample, left_hist_q[3:1]};
          right_hist_q <= {in_i.right_sample, right_hist_q[3:1]};
        end
      end
    end
  end

  // Output item register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= res_l;
      out_right_q <= res_r;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.left_out    = out_left_q;
  assign out_o.right_out   = out_right_q;
  assign out_o.last_of_run = out_last_q;

  shr_datapath u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .phase_i      (phase_q[P_W-1:0]),
    .left_hist_i  (left_hist_q),
    .right_hist_i (right_hist_q),
    .left_res_o   (res_l),
    .right_res_o  (res_r)
  );

endmodule
